// File: design/srb_pkg.sv
// ----------------------------------------------------------------------------
// Sequence reorder buffer package
// Shared packet kind codes, result status codes and slot store sizes.
// ----------------------------------------------------------------------------
package srb_pkg;

  // The slot store is indexed by the low bits of the sequence number.
  localparam int unsigned SlotBits   = 6;
  localparam int unsigned SlotCount  = 1 << SlotBits;

  // One input beat causes at most this many result beats.
  localparam int unsigned MaxResults = 32;
  localparam int unsigned CountBits  = $clog2(MaxResults + 1);

  typedef logic [1:0] kind_t;

  localparam kind_t KindSend   = 2'd0;
  localparam kind_t KindCancel = 2'd1;

  typedef enum logic [2:0] {
    StDelivered = 3'd0,
    StPassed    = 3'd1,
    StCancel    = 3'd2,
    StOutside   = 3'd3,
    StDuplicate = 3'd4
  } status_e;

endpackage

// File: design/sequence_reorder_buffer_core.sv
// ----------------------------------------------------------------------------
// Sequence reorder buffer core
// Delivers sequenced packets in order, parking early ones in a slot store.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o) takes one packet per beat:
//   kind, sequence number and tag. The output channel (out_valid_o /
//   out_ready_i) returns result beats; last_o marks the final result beat of
//   an input beat. An input beat that is parked in the slot store gives no
//   result beat of its own.
//   The first result of an input beat is registered and shows in the cycle
//   after acceptance. While no drain is pending, a new input beat is taken
//   every cycle that the receiver takes the previous result.
//   When in-order packets are waiting in the store, they are drained one per
//   cycle while the receiver takes each result, limited by the single read
//   port of the tag memory; input stays blocked until the drain ends.
//   A drain stops after 32 result beats for one input beat; the rest drains
//   after the results of the next input beat.
//   Reset clears the expected number and all slot valid flags at once, so
//   input can be taken once reset is released. When the receiver stalls,
//   the result register holds its beat and input is held off.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer_core #(
  parameter int unsigned WINDOW   = 32,
  parameter int unsigned SEQ_BITS = 16,
  parameter int unsigned TAG_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  pkt_kind_i,
  input  logic [15:0] seq_num_i,
  input  logic [31:0] packet_tag_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] out_tag_o,
  output logic [15:0] out_seq_o,
  output logic        last_o
);

  localparam int unsigned SlotBits  = srb_pkg::SlotBits;
  localparam int unsigned SlotCount = srb_pkg::SlotCount;
  localparam int unsigned CountBits = srb_pkg::CountBits;

  typedef enum logic {
    StateIdle,
    StateDrain
  } state_e;

  state_e                 state_q;
  logic [SEQ_BITS-1:0]    expected_q;
  logic [SlotCount-1:0]   valid_q;
  logic [CountBits-1:0]   count_q;
  logic                   out_valid_q;
  srb_pkg::status_e       status_q;
  logic [31:0]            out_tag_q;
  logic [15:0]            out_seq_q;
  logic                   last_q;

  logic [TAG_BITS-1:0]    tag_mem [SlotCount];
  logic [TAG_BITS-1:0]    rd_data_q;

  logic [SEQ_BITS-1:0]    seq_in;
  logic [TAG_BITS-1:0]    tag_in;
  logic [SEQ_BITS-1:0]    seq_dist;
  logic                   in_order;
  logic                   in_window;
  logic [SlotBits-1:0]    wr_idx;
  logic                   out_free;
  logic                   accept;
  logic                   have_first;
  logic                   do_store;
  srb_pkg::status_e       first_status;
  logic [SEQ_BITS-1:0]    exp_next_acc;
  logic [SlotBits-1:0]    acc_idx;
  logic                   acc_drain;
  logic [SlotBits-1:0]    drain_idx;
  logic [SEQ_BITS-1:0]    exp_inc;
  logic [SlotBits-1:0]    inc_idx;
  logic                   drain_emit;
  logic [CountBits-1:0]   count_inc;
  logic                   drain_more;
  logic [SlotBits-1:0]    rd_idx;
  logic                   out_load;

  assign seq_in    = SEQ_BITS'(seq_num_i);
  assign tag_in    = TAG_BITS'(packet_tag_i);
  assign seq_dist  = seq_in - expected_q;
  assign in_order  = (pkt_kind_i == srb_pkg::KindSend) && (seq_dist == '0);
  assign in_window = seq_dist < SEQ_BITS'(WINDOW);
  assign wr_idx    = seq_in[SlotBits-1:0];

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StateIdle) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    have_first   = 1'b1;
    do_store     = 1'b0;
    first_status = srb_pkg::StPassed;
    case (pkt_kind_i)
      srb_pkg::KindSend: begin
        if (seq_dist == '0) begin
          first_status = srb_pkg::StDelivered;
        end else if (in_window) begin
          if (valid_q[wr_idx]) begin
            first_status = srb_pkg::StDuplicate;
          end else begin
            have_first = 1'b0;
            do_store   = 1'b1;
          end
        end else begin
          first_status = srb_pkg::StOutside;
        end
      end
      srb_pkg::KindCancel: first_status = srb_pkg::StCancel;
      default:             first_status = srb_pkg::StPassed;
    endcase
  end

  // A stored slot never aliases the expected slot, so the drain check can
  // use the flags as they stand before this beat's store.
  assign exp_next_acc = expected_q + SEQ_BITS'(in_order);
  assign acc_idx      = exp_next_acc[SlotBits-1:0];
  assign acc_drain    = valid_q[acc_idx];

  assign drain_idx  = expected_q[SlotBits-1:0];
  assign exp_inc    = expected_q + SEQ_BITS'(1);
  assign inc_idx    = exp_inc[SlotBits-1:0];
  assign drain_emit = (state_q == StateDrain) && out_free;
  assign count_inc  = count_q + CountBits'(1);
  assign drain_more = valid_q[inc_idx] && (count_inc != CountBits'(srb_pkg::MaxResults));

  assign out_load = (accept && have_first) || drain_emit;

  // On acceptance and in a drain, the read address is the slot of the next
  // expected number, so read data is ready for one drain beat per cycle.
  always_comb begin
    if (state_q == StateIdle) begin
      rd_idx = acc_idx;
    end else if (drain_emit) begin
      rd_idx = inc_idx;
    end else begin
      rd_idx = drain_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && do_store) begin
      tag_mem[wr_idx] <= tag_in;
    end
    rd_data_q <= tag_mem[rd_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateIdle;
      expected_q  <= '0;
      valid_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= srb_pkg::StDelivered;
      out_tag_q   <= '0;
      out_seq_q   <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StateIdle: begin
          if (accept) begin
            if (do_store) begin
              valid_q[wr_idx] <= 1'b1;
            end
            expected_q <= exp_next_acc;
            if (have_first) begin
              out_valid_q <= 1'b1;
              status_q    <= first_status;
              out_tag_q   <= 32'(tag_in);
              out_seq_q   <= 16'(seq_in);
              last_q      <= !acc_drain;
              count_q     <= CountBits'(1);
            end else begin
              count_q <= '0;
            end
            if (acc_drain) begin
              state_q <= StateDrain;
            end
          end
        end
        StateDrain: begin
          if (drain_emit) begin
            out_valid_q        <= 1'b1;
            status_q           <= srb_pkg::StDelivered;
            out_tag_q          <= 32'(rd_data_q);
            out_seq_q          <= 16'(expected_q);
            last_q             <= !drain_more;
            valid_q[drain_idx] <= 1'b0;
            expected_q         <= exp_inc;
            count_q            <= count_inc;
            if (!drain_more) begin
              state_q <= StateIdle;
            end
          end
        end
        default: state_q <= StateIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_tag_o   = out_tag_q;
  assign out_seq_o   = out_seq_q;
  assign last_o      = last_q;

endmodule

// File: design/srb_checker.sv
// ----------------------------------------------------------------------------
// Sequence reorder buffer checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
module srb_checker #(
  parameter int unsigned SEQ_BITS = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [31:0] out_tag_o,
  input logic [15:0] out_seq_o,
  input logic        last_o
);

  logic [SEQ_BITS-1:0] seq_wide;
  logic [SEQ_BITS-1:0] seq_wrap;
  logic [15:0]         seq_next;
  logic                delivered;

  assign seq_wide  = SEQ_BITS'(out_seq_o);
  assign seq_wrap  = seq_wide + SEQ_BITS'(1);
  assign seq_next  = 16'(seq_wrap);
  assign delivered = status_o == 3'(srb_pkg::StDelivered);

  // A stalled result beat holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(out_tag_o) && $stable(out_seq_o) && $stable(last_o))
    else $error("result beat changed while stalled");

  // Input stays blocked while an input beat still owes result beats.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input accepted in the middle of a result train");

  // Within a result train, an in-order delivery is followed at once by the
  // delivery of the next sequence number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o && delivered |=>
      out_valid_o && delivered && (out_seq_o == $past(seq_next)))
    else $error("drain did not continue with the next sequence number");

  // No input beat is accepted while a stalled result beat fills the output
  // register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && out_valid_o && !out_ready_i |-> 1'b0)
    else $error("input accepted while the result register is full");

endmodule

bind sequence_reorder_buffer_core srb_checker #(
  .SEQ_BITS(SEQ_BITS)
) u_srb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .status_o   (status_o),
  .out_tag_o  (out_tag_o),
  .out_seq_o  (out_seq_o),
  .last_o     (last_o)
);

// File: verif/srb_tb_pkg.sv
// ----------------------------------------------------------------------------
// Sequence reorder buffer scoreboard
// Predicts the result beats of the reorder buffer from the accepted input
// beats and compares each result beat with the oldest one still expected.
// ----------------------------------------------------------------------------
package srb_tb_pkg;

  import srb_pkg::*;

  localparam kind_t KindOther = 2'd2;
  localparam kind_t KindSpare = 2'd3;

  localparam int unsigned Window = 32;

  typedef struct packed {
    status_e     status;
    logic [31:0] tag;
    logic [15:0] seq;
    logic        last;
  } result_t;

  class reorder_scoreboard;

    logic [15:0] next_seq;
    bit          held     [SlotCount];
    logic [31:0] held_tag [SlotCount];
    result_t     expected_q [$];
    int unsigned errors;

    function new();
      next_seq = '0;
      foreach (held[i]) begin
        held[i]     = 1'b0;
        held_tag[i] = '0;
      end
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void push(status_e status, logic [31:0] tag, logic [15:0] seq);
      result_t r;
      r.status = status;
      r.tag    = tag;
      r.seq    = seq;
      r.last   = 1'b0;
      expected_q.push_back(r);
    endfunction

    function void note_beat(kind_t kind, logic [15:0] seq, logic [31:0] tag);
      int unsigned          first;
      logic [15:0]          seq_dist;
      logic [SlotBits-1:0]  idx;
      bit                   draining;
      result_t              r;
      first = expected_q.size();
      if (kind == KindSend) begin
        seq_dist = seq - next_seq;
        if (seq_dist == 16'd0) begin
          push(StDelivered, tag, seq);
          next_seq = next_seq + 16'd1;
        end else if (seq_dist < Window) begin
          idx = seq[SlotBits-1:0];
          if (held[idx]) begin
            push(StDuplicate, tag, seq);
          end else begin
            held[idx]     = 1'b1;
            held_tag[idx] = tag;
          end
        end else begin
          push(StOutside, tag, seq);
        end
      end else if (kind == KindCancel) begin
        push(StCancel, tag, seq);
      end else begin
        push(StPassed, tag, seq);
      end
      // Release parked packets that are now in order, up to the per-beat cap.
      draining = 1'b1;
      while (draining && (expected_q.size() - first < MaxResults)) begin
        idx = next_seq[SlotBits-1:0];
        if (!held[idx]) begin
          draining = 1'b0;
        end else begin
          push(StDelivered, held_tag[idx], next_seq);
          held[idx] = 1'b0;
          next_seq  = next_seq + 16'd1;
        end
      end
      if (expected_q.size() > first) begin
        r      = expected_q.pop_back();
        r.last = 1'b1;
        expected_q.push_back(r);
      end
    endfunction

    function void check_beat(logic [2:0] status, logic [31:0] tag, logic [15:0] seq,
                             logic last, longint unsigned stamp);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0d ns: unexpected result beat: status %0d tag %h seq %h last %b",
                 stamp, status, tag, seq, last);
        return;
      end
      want = expected_q.pop_front();
      if (status !== want.status) begin
        errors++;
        $display("%0d ns: status mismatch: expected %0d, actual %0d",
                 stamp, want.status, status);
      end
      if (tag !== want.tag) begin
        errors++;
        $display("%0d ns: out_tag mismatch: expected %h, actual %h", stamp, want.tag, tag);
      end
      if (seq !== want.seq) begin
        errors++;
        $display("%0d ns: out_seq mismatch: expected %h, actual %h", stamp, want.seq, seq);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0d ns: last mismatch: expected %b, actual %b", stamp, want.last, last);
      end
    endfunction

  endclass

endpackage

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// Sequence reorder buffer testbench
// Drives directed and random packet beats with random idling on both
// channels and checks every result beat against the scoreboard prediction.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import srb_pkg::*;
  import srb_tb_pkg::*;

  localparam int unsigned IdleLimit   = 200;
  localparam int unsigned TailCycles  = 40;
  localparam int unsigned RandomBeats = 210;
  localparam int unsigned QuietTail   = 40;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic [1:0]  pkt_kind_i   = '0;
  logic [15:0] seq_num_i    = '0;
  logic [31:0] packet_tag_i = '0;
  logic        out_ready_i  = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [2:0]  status_o;
  logic [31:0] out_tag_o;
  logic [15:0] out_seq_o;
  logic        last_o;

  reorder_scoreboard board = new();
  bit                idle_on = 1'b0;
  int unsigned       stall_left = 0;
  int unsigned       quiet_cycles = 0;

  sequence_reorder_buffer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pkt_kind_i  (pkt_kind_i),
    .seq_num_i   (seq_num_i),
    .packet_tag_i(packet_tag_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .out_tag_o   (out_tag_o),
    .out_seq_o   (out_seq_o),
    .last_o      (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver: check each accepted result beat, then stall in short bursts.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      board.check_beat(status_o, out_tag_o, out_seq_o, last_o, $time);
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IdleLimit) begin
      $display("%0d ns: no beat accepted for %0d cycles", $time, IdleLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one beat, hold it until accepted, then maybe leave a short gap.
  task automatic send_beat(kind_t kind, logic [15:0] seq, logic [31:0] tag);
    in_valid_i   <= 1'b1;
    pkt_kind_i   <= kind;
    seq_num_i    <= seq;
    packet_tag_i <= tag;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_beat(kind, seq, tag);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned j;
    int unsigned swap;
    int unsigned plan [$];
    logic [15:0] base;
    logic [15:0] seq;
    logic [31:0] tag;
    kind_t       kind;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_on = 1'b1;
    send_beat(KindOther,  16'h0000, 32'h0000_0000);
    send_beat(KindSpare,  16'hffff, 32'hffff_ffff);
    send_beat(KindCancel, 16'h1234, 32'ha5a5_a5a5);
    send_beat(KindSend,   16'h0000, 32'hffff_ffff);  // in order
    send_beat(KindSend,   16'h0000, 32'h1111_1111);  // just behind the expected number
    send_beat(KindSend,   16'h8001, 32'h2222_2222);  // far outside
    send_beat(KindSend,   16'd32,   32'h3333_3333);  // farthest distance that still parks
    send_beat(KindSend,   16'd33,   32'h4444_4444);  // one past the window
    send_beat(KindSend,   16'd3,    32'h5555_5555);
    send_beat(KindSend,   16'd2,    32'h6666_6666);
    send_beat(KindSend,   16'd3,    32'h7777_7777);  // slot already full
    send_beat(KindCancel, 16'hffff, 32'h0000_0000);
    send_beat(KindSend,   16'd1,    32'h8888_8888);  // releases 2 and 3
    send_beat(KindSend,   16'hffff, 32'h9999_9999);
    send_beat(KindOther,  16'hffff, 32'h0000_0000);
    send_beat(KindSpare,  16'h0000, 32'hffff_ffff);

    wait_drained();

    // Mostly well-formed runs of consecutive numbers in shuffled order,
    // mixed with noise beats and runs that leave a hole behind.
    sent = 0;
    while (sent < RandomBeats) begin
      if (plan.size() == 0) begin
        if ($urandom_range(0, 9) == 0) begin
          wait_drained();
        end
        idle_on = (sent < RandomBeats - QuietTail) && ($urandom_range(0, 3) != 0);
        n = ($urandom_range(0, 7) == 0) ? Window : $urandom_range(1, 8);
        for (int i = 0; i < n; i++) plan.push_back(i);
        for (int i = n - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          swap = plan[i];
          plan[i] = plan[j];
          plan[j] = swap;
        end
        if ($urandom_range(0, 1) == 0) begin
          // Hold the in-order packet back so the whole run drains at once.
          for (int i = 0; i < n; i++) begin
            if (plan[i] == 0) begin
              plan[i] = plan[n-1];
              plan[n-1] = 0;
            end
          end
        end
        if (n > 1 && $urandom_range(0, 4) == 0) begin
          plan.delete($urandom_range(0, n - 1));
        end
        base = board.next_seq;
      end
      if (sent >= RandomBeats - QuietTail) begin
        idle_on = 1'b0;
      end
      tag = $urandom;
      if ($urandom_range(0, 3) == 0) begin
        kind = kind_t'($urandom_range(0, 3));
        seq  = 16'($urandom);
      end else if ($urandom_range(0, 11) == 0) begin
        kind = KindSend;
        seq  = base + 16'($urandom_range(0, n - 1));
      end else begin
        kind = KindSend;
        seq  = base + 16'(plan.pop_front());
      end
      send_beat(kind, seq, tag);
      sent++;
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
    repeat (TailCycles) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
